// ===== hdl/assert_macros.svh =====
// Assertion helpers used by the lock manager RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define RWLM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("rwlm assertion failed");

// next-cycle implication
`define RWLM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("rwlm assertion failed");

`endif

// ===== hdl/rwlm_pkg.sv =====
`timescale 1ns / 1ps

package rwlm_pkg;

	localparam int TASK_W        = 4;
	localparam int CMD_W         = 3;
	localparam int STS_W         = 3;
	localparam int NUM_IDS       = 1 << TASK_W;
	localparam int MAX_TASKS_DEF = 16;

	localparam logic [CMD_W-1:0] CMD_LOCK_EXCL   = 3'd0;
	localparam logic [CMD_W-1:0] CMD_LOCK_SHARED = 3'd1;
	localparam logic [CMD_W-1:0] CMD_TRY_EXCL    = 3'd2;
	localparam logic [CMD_W-1:0] CMD_TRY_SHARED  = 3'd3;
	localparam logic [CMD_W-1:0] CMD_UNLK_EXCL   = 3'd4;
	localparam logic [CMD_W-1:0] CMD_UNLK_SHARED = 3'd5;

	localparam logic [STS_W-1:0] ST_GRANTED  = 3'd0;
	localparam logic [STS_W-1:0] ST_QUEUED   = 3'd1;
	localparam logic [STS_W-1:0] ST_REFUSED  = 3'd2;
	localparam logic [STS_W-1:0] ST_RELEASED = 3'd3;
	localparam logic [STS_W-1:0] ST_IGNORED  = 3'd4;
	localparam logic [STS_W-1:0] ST_DEADLOCK = 3'd5;
	localparam logic [STS_W-1:0] ST_RESUMED  = 3'd6;

	typedef struct packed {
		logic [CMD_W-1:0]  command;
		logic [TASK_W-1:0] task_id;
	} req_t;

	typedef struct packed {
		logic [STS_W-1:0]  status;
		logic [TASK_W-1:0] result_task;
		logic              grant_shared;
		logic              last;
	} rsp_t;

	typedef struct packed {
		logic              shared;
		logic [TASK_W-1:0] task_id;
	} qent_t;

	// controller -> datapath
	typedef struct packed {
		logic accept;
		logic pop;
	} ctl_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic out_valid;
		logic need_resume;
		logic pop_last;
	} dp_sts_t;

endpackage

// ===== hdl/reader_writer_lock_manager.sv =====
`timescale 1ns / 1ps

// Reader-writer lock manager with a FIFO wait queue of MAX_TASKS entries. Each
// request item is decided in the cycle it is accepted and gives one result item
// from the output register; an unlock that frees the lock then resumes queued
// tasks, one result item per cycle while results are taken without stall (the
// head of the queue memory is read one entry ahead). Requests are stalled while
// resumed tasks are being emitted. The last field marks the final result of each
// request.
`include "assert_macros.svh"

module reader_writer_lock_manager #(
	parameter int MAX_TASKS = rwlm_pkg::MAX_TASKS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  rwlm_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output rwlm_pkg::rsp_t rsp
);

	rwlm_pkg::ctl_cmd_t ctl_cmd;
	rwlm_pkg::dp_sts_t  dp_sts;

	rwlm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp_stall (rsp_stall),
		.sts       (dp_sts),
		.cmd       (ctl_cmd)
	);

	rwlm_datapath #(
		.MAX_TASKS (MAX_TASKS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (ctl_cmd),
		.rsp_stall (rsp_stall),
		.sts       (dp_sts),
		.rsp       (rsp)
	);

	assign rsp_valid = dp_sts.out_valid;

	`RWLM_ASSERT_NOW(a_no_mix, clk, arst_n, ctl_cmd.pop, !ctl_cmd.accept && req_stall)
	`RWLM_ASSERT_NEXT(a_single, clk, arst_n, ctl_cmd.accept && !dp_sts.need_resume, rsp_valid && rsp.last)
	`RWLM_ASSERT_NEXT(a_multi, clk, arst_n, ctl_cmd.accept && dp_sts.need_resume, rsp_valid && !rsp.last && req_stall)
	`RWLM_ASSERT_NEXT(a_resume, clk, arst_n, ctl_cmd.pop, rsp_valid && rsp.status == rwlm_pkg::ST_RESUMED)

endmodule

// ===== hdl/rwlm_datapath.sv =====
`timescale 1ns / 1ps

module rwlm_datapath #(
	parameter int MAX_TASKS = rwlm_pkg::MAX_TASKS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  rwlm_pkg::req_t     req,
	input  rwlm_pkg::ctl_cmd_t cmd,
	input  logic               rsp_stall,
	output rwlm_pkg::dp_sts_t  sts,
	output rwlm_pkg::rsp_t     rsp
);

	localparam int IW = $clog2(MAX_TASKS);
	localparam int CW = $clog2(MAX_TASKS + 1);
	localparam int NI = rwlm_pkg::NUM_IDS;
	localparam logic [IW-1:0] LAST_IDX = IW'(MAX_TASKS - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(MAX_TASKS);
	localparam logic [IW:0]   DEPTH    = (IW+1)'(MAX_TASKS);

	function automatic logic [IW-1:0] wrap_inc(input logic [IW-1:0] a);
		wrap_inc = (a == LAST_IDX) ? '0 : a + 1'b1;
	endfunction

	logic                        excl_q;
	logic [rwlm_pkg::TASK_W-1:0] writer_q;
	logic [NI-1:0]               readers_q;
	logic [IW-1:0]               head_q;
	logic [CW-1:0]               count_q;
	logic                        rsp_valid_q;
	rwlm_pkg::rsp_t              rsp_q;
	rwlm_pkg::qent_t             mem [MAX_TASKS];
	rwlm_pkg::qent_t             rd0_q;
	rwlm_pkg::qent_t             rd1_q;

	logic [NI-1:0]               tbit;
	logic [NI-1:0]               pbit;
	logic                        is_free;
	logic                        can_join;
	logic                        full;
	logic [rwlm_pkg::STS_W-1:0]  st;
	logic                        shr;
	logic                        set_w;
	logic                        clr_w;
	logic                        set_r;
	logic                        clr_r;
	logic                        want_q;
	logic                        enq;
	logic                        resume;
	logic [IW:0]                 tsum;
	logic [IW-1:0]               tail;
	logic [IW-1:0]               head_nxt;
	logic                        pop_last;

	always_comb begin
		tbit     = {{(NI-1){1'b0}}, 1'b1} << req.task_id;
		pbit     = {{(NI-1){1'b0}}, 1'b1} << rd0_q.task_id;
		is_free  = !excl_q && (readers_q == '0);
		can_join = is_free || (!excl_q && (count_q == '0));
		full     = (count_q == FULL_CNT);
		st       = rwlm_pkg::ST_IGNORED;
		shr      = 1'b0;
		set_w    = 1'b0;
		clr_w    = 1'b0;
		set_r    = 1'b0;
		clr_r    = 1'b0;
		want_q   = 1'b0;
		resume   = 1'b0;
		unique case (req.command)
			rwlm_pkg::CMD_LOCK_EXCL: begin
				if (is_free) begin
					st    = rwlm_pkg::ST_GRANTED;
					set_w = 1'b1;
				end else if ((excl_q && writer_q == req.task_id) ||
						(!excl_q && (readers_q & tbit) != '0)) begin
					st = rwlm_pkg::ST_DEADLOCK;
				end else begin
					want_q = 1'b1;
				end
			end
			rwlm_pkg::CMD_LOCK_SHARED: begin
				if (can_join) begin
					st    = rwlm_pkg::ST_GRANTED;
					shr   = 1'b1;
					set_r = 1'b1;
				end else begin
					want_q = 1'b1;
				end
			end
			rwlm_pkg::CMD_TRY_EXCL: begin
				if (is_free) begin
					st    = rwlm_pkg::ST_GRANTED;
					set_w = 1'b1;
				end else begin
					st = rwlm_pkg::ST_REFUSED;
				end
			end
			rwlm_pkg::CMD_TRY_SHARED: begin
				if (can_join) begin
					st    = rwlm_pkg::ST_GRANTED;
					shr   = 1'b1;
					set_r = 1'b1;
				end else begin
					st = rwlm_pkg::ST_REFUSED;
				end
			end
			rwlm_pkg::CMD_UNLK_EXCL: begin
				if (excl_q && writer_q == req.task_id) begin
					st     = rwlm_pkg::ST_RELEASED;
					clr_w  = 1'b1;
					resume = (count_q != '0);
				end
			end
			rwlm_pkg::CMD_UNLK_SHARED: begin
				if (!excl_q && (readers_q & tbit) != '0) begin
					st     = rwlm_pkg::ST_RELEASED;
					clr_r  = 1'b1;
					resume = ((readers_q & ~tbit) == '0) && (count_q != '0);
				end
			end
			default: begin
				st = rwlm_pkg::ST_IGNORED;
			end
		endcase
		enq = want_q && !full;
		if (want_q) begin
			st = full ? rwlm_pkg::ST_REFUSED : rwlm_pkg::ST_QUEUED;
		end
		shr = shr && !want_q;
	end

	assign tsum     = {1'b0, head_q} + (IW+1)'(count_q);
	assign tail     = (tsum >= DEPTH) ? IW'(tsum - DEPTH) : tsum[IW-1:0];
	assign head_nxt = cmd.pop ? wrap_inc(head_q) : head_q;
	assign pop_last = !rd0_q.shared || (count_q == CW'(1)) || !rd1_q.shared;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			excl_q      <= 1'b0;
			writer_q    <= '0;
			readers_q   <= '0;
			head_q      <= '0;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd.accept) begin
				if (set_w) begin
					excl_q   <= 1'b1;
					writer_q <= req.task_id;
				end
				if (clr_w) begin
					excl_q <= 1'b0;
				end
				if (set_r) begin
					readers_q <= readers_q | tbit;
				end
				if (clr_r) begin
					readers_q <= readers_q & ~tbit;
				end
				if (enq) begin
					count_q <= count_q + 1'b1;
				end
			end
			if (cmd.pop) begin
				head_q  <= head_nxt;
				count_q <= count_q - 1'b1;
				if (rd0_q.shared) begin
					readers_q <= readers_q | pbit;
				end else begin
					excl_q   <= 1'b1;
					writer_q <= rd0_q.task_id;
				end
			end
			if (cmd.accept || cmd.pop) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// wait queue: write at tail, read head and head+1 ahead of the pop
	always_ff @(posedge clk) begin
		if (cmd.accept && enq) begin
			mem[tail] <= '{shared: req.command[0], task_id: req.task_id};
		end
		rd0_q <= mem[head_nxt];
		rd1_q <= mem[wrap_inc(head_nxt)];
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			rsp_q <= '{status: st, result_task: req.task_id, grant_shared: shr,
				last: !resume};
		end else if (cmd.pop) begin
			rsp_q <= '{status: rwlm_pkg::ST_RESUMED, result_task: rd0_q.task_id,
				grant_shared: rd0_q.shared, last: pop_last};
		end
	end

	assign sts.out_valid   = rsp_valid_q;
	assign sts.need_resume = resume;
	assign sts.pop_last    = pop_last;
	assign rsp             = rsp_q;

endmodule

// ===== hdl/rwlm_ctrl.sv =====
`timescale 1ns / 1ps

module rwlm_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	input  logic               rsp_stall,
	input  rwlm_pkg::dp_sts_t  sts,
	output rwlm_pkg::ctl_cmd_t cmd
);

	typedef enum logic [1:0] {
		S_IDLE   = 2'b01,
		S_RESUME = 2'b10
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   out_free;

	assign out_free = !sts.out_valid || !rsp_stall;

	always_comb begin
		state_d    = state_q;
		req_stall  = 1'b1;
		cmd.accept = 1'b0;
		cmd.pop    = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				req_stall  = !out_free;
				cmd.accept = req_valid && out_free;
				if (cmd.accept && sts.need_resume) begin
					state_d = S_RESUME;
				end
			end
			S_RESUME: begin
				cmd.pop = out_free;
				if (cmd.pop && sts.pop_last) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== bench/reader_writer_lock_manager_tb.sv =====
`timescale 1ns / 1ps

module reader_writer_lock_manager_tb;
	import rwlm_pkg::*;

	localparam int QDEPTH = MAX_TASKS_DEF;
	localparam int CYCLE_LIMIT = 400000;
	localparam logic [CMD_W-1:0] CMD_UNUSED_A = 3'd6;
	localparam logic [CMD_W-1:0] CMD_UNUSED_B = 3'd7;

	logic clk;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	int req_idle_pct = 0;
	int rsp_idle_pct = 0;
	int error_count = 0;
	int request_count = 0;
	int result_count = 0;
	int cycle_count = 0;

	// lock state mirror
	logic excl_held;
	logic [TASK_W-1:0] writer_id;
	logic [NUM_IDS-1:0] reader_mask;
	qent_t wait_q[QDEPTH];
	int wait_head;
	int wait_count;

	rsp_t step_results[$];
	rsp_t expected_rsp[$];

	reader_writer_lock_manager dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic void note_result(logic [STS_W-1:0] st, logic [TASK_W-1:0] tid, logic sh);
		rsp_t r;
		r.status = st;
		r.result_task = tid;
		r.grant_shared = sh;
		r.last = 1'b0;
		step_results.push_back(r);
	endfunction

	function automatic void wait_for_lock(logic [TASK_W-1:0] tid, logic sh);
		qent_t e;
		if (wait_count >= QDEPTH) begin
			note_result(ST_REFUSED, tid, 1'b0);
		end else begin
			e.shared = sh;
			e.task_id = tid;
			wait_q[(wait_head + wait_count) % QDEPTH] = e;
			wait_count++;
			note_result(ST_QUEUED, tid, 1'b0);
		end
	endfunction

	function automatic void wake_waiters();
		logic [TASK_W-1:0] tid;
		if (wait_count != 0) begin
			if (!wait_q[wait_head].shared) begin
				tid = wait_q[wait_head].task_id;
				wait_head = (wait_head + 1) % QDEPTH;
				wait_count--;
				excl_held = 1'b1;
				writer_id = tid;
				note_result(ST_RESUMED, tid, 1'b0);
			end else begin
				while (wait_count != 0 && wait_q[wait_head].shared) begin
					tid = wait_q[wait_head].task_id;
					wait_head = (wait_head + 1) % QDEPTH;
					wait_count--;
					reader_mask[tid] = 1'b1;
					note_result(ST_RESUMED, tid, 1'b1);
				end
			end
		end
	endfunction

	function automatic void predict_request(req_t r);
		logic is_free;
		logic readers_hold;
		logic can_join;
		logic [TASK_W-1:0] tid;
		tid = r.task_id;
		is_free = !excl_held && reader_mask == '0;
		readers_hold = !excl_held && reader_mask != '0;
		can_join = is_free || (readers_hold && wait_count == 0);
		step_results.delete();
		case (r.command)
			CMD_LOCK_EXCL: begin
				if (is_free) begin
					excl_held = 1'b1;
					writer_id = tid;
					note_result(ST_GRANTED, tid, 1'b0);
				end else if ((excl_held && writer_id == tid) ||
						(!excl_held && reader_mask[tid])) begin
					note_result(ST_DEADLOCK, tid, 1'b0);
				end else begin
					wait_for_lock(tid, 1'b0);
				end
			end
			CMD_LOCK_SHARED: begin
				if (can_join) begin
					reader_mask[tid] = 1'b1;
					note_result(ST_GRANTED, tid, 1'b1);
				end else begin
					wait_for_lock(tid, 1'b1);
				end
			end
			CMD_TRY_EXCL: begin
				if (is_free) begin
					excl_held = 1'b1;
					writer_id = tid;
					note_result(ST_GRANTED, tid, 1'b0);
				end else begin
					note_result(ST_REFUSED, tid, 1'b0);
				end
			end
			CMD_TRY_SHARED: begin
				if (can_join) begin
					reader_mask[tid] = 1'b1;
					note_result(ST_GRANTED, tid, 1'b1);
				end else begin
					note_result(ST_REFUSED, tid, 1'b0);
				end
			end
			CMD_UNLK_EXCL: begin
				if (excl_held && writer_id == tid) begin
					excl_held = 1'b0;
					note_result(ST_RELEASED, tid, 1'b0);
					wake_waiters();
				end else begin
					note_result(ST_IGNORED, tid, 1'b0);
				end
			end
			CMD_UNLK_SHARED: begin
				if (!excl_held && reader_mask[tid]) begin
					reader_mask[tid] = 1'b0;
					note_result(ST_RELEASED, tid, 1'b0);
					if (reader_mask == '0) begin
						wake_waiters();
					end
				end else begin
					note_result(ST_IGNORED, tid, 1'b0);
				end
			end
			default: begin
				note_result(ST_IGNORED, tid, 1'b0);
			end
		endcase
		step_results[step_results.size() - 1].last = 1'b1;
		foreach (step_results[i]) begin
			expected_rsp.push_back(step_results[i]);
		end
	endfunction

	task automatic send_request(logic [CMD_W-1:0] cmd, logic [TASK_W-1:0] tid);
		req_t item;
		item.command = cmd;
		item.task_id = tid;
		while ($urandom_range(99) < req_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req <= item;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		predict_request(item);
		request_count++;
	endtask

	always @(posedge clk) begin
		rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
	end

	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			result_count++;
			if (expected_rsp.size() == 0) begin
				$display("%0t: unexpected result status=%0d task=%0d shared=%0b last=%0b",
					$time, rsp.status, rsp.result_task, rsp.grant_shared, rsp.last);
				error_count++;
			end else begin
				want = expected_rsp.pop_front();
				if (rsp.status !== want.status || rsp.result_task !== want.result_task ||
						rsp.grant_shared !== want.grant_shared || rsp.last !== want.last) begin
					$display("%0t: mismatch expected status=%0d task=%0d shared=%0b last=%0b",
						$time, want.status, want.result_task, want.grant_shared, want.last);
					$display("%0t:          actual   status=%0d task=%0d shared=%0b last=%0b",
						$time, rsp.status, rsp.result_task, rsp.grant_shared, rsp.last);
					error_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d results outstanding",
				cycle_count, expected_rsp.size());
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// grants, deadlocks, foreign unlocks, queueing and resumption
	task automatic test_basic_locking();
		send_request(CMD_LOCK_EXCL, 4'd0);
		send_request(CMD_LOCK_EXCL, 4'd0);
		send_request(CMD_LOCK_SHARED, 4'd0);
		send_request(CMD_TRY_EXCL, 4'd1);
		send_request(CMD_TRY_SHARED, 4'd1);
		send_request(CMD_UNLK_SHARED, 4'd5);
		send_request(CMD_UNLK_EXCL, 4'd15);
		send_request(CMD_UNUSED_A, 4'd3);
		send_request(CMD_UNUSED_B, 4'd12);
		send_request(CMD_LOCK_EXCL, 4'd15);
		send_request(CMD_UNLK_EXCL, 4'd0);
		send_request(CMD_LOCK_SHARED, 4'd3);
		send_request(CMD_LOCK_EXCL, 4'd0);
		send_request(CMD_UNLK_SHARED, 4'd0);
		send_request(CMD_UNLK_EXCL, 4'd15);
		send_request(CMD_LOCK_SHARED, 4'd3);
		send_request(CMD_TRY_SHARED, 4'd9);
		send_request(CMD_UNLK_SHARED, 4'd3);
		send_request(CMD_UNLK_SHARED, 4'd9);
		send_request(CMD_TRY_EXCL, 4'd10);
		send_request(CMD_UNLK_SHARED, 4'd10);
		send_request(CMD_UNLK_EXCL, 4'd10);
	endtask

	// sixteen readers behind a writer, one refused, then all resumed at once
	task automatic test_full_queue();
		send_request(CMD_LOCK_EXCL, 4'd7);
		for (int i = 0; i < QDEPTH; i++) begin
			send_request(CMD_LOCK_SHARED, 4'(i));
		end
		send_request(CMD_LOCK_EXCL, 4'd2);
		send_request(CMD_UNLK_EXCL, 4'd7);
	endtask

	// mostly holders releasing and new lock attempts, some raw noise
	task automatic test_random_traffic(int send_pct, int recv_pct, int count);
		int k;
		int start;
		int idx;
		logic [CMD_W-1:0] cmd;
		logic [TASK_W-1:0] tid;
		req_idle_pct = send_pct;
		rsp_idle_pct = recv_pct;
		for (int n = 0; n < count; n++) begin
			k = $urandom_range(99);
			tid = 4'($urandom_range(NUM_IDS - 1));
			if (k < 15) begin
				cmd = 3'($urandom_range(7));
			end else if (k < 55 && (excl_held || reader_mask != '0)) begin
				if (excl_held) begin
					cmd = CMD_UNLK_EXCL;
					tid = writer_id;
				end else begin
					cmd = CMD_UNLK_SHARED;
					start = $urandom_range(NUM_IDS - 1);
					for (int j = 0; j < NUM_IDS; j++) begin
						idx = (start + j) % NUM_IDS;
						if (reader_mask[idx]) begin
							tid = 4'(idx);
						end
					end
				end
			end else begin
				cmd = 3'($urandom_range(3));
			end
			send_request(cmd, tid);
		end
	endtask

	initial begin
		excl_held = 1'b0;
		writer_id = '0;
		reader_mask = '0;
		wait_head = 0;
		wait_count = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		req_idle_pct = 38;
		rsp_idle_pct = 73;
		test_basic_locking();
		test_full_queue();
		test_random_traffic(38, 73, 20);
		test_random_traffic(73, 38, 20);
		test_random_traffic(0, 0, 20);
		req_valid <= 1'b0;
		while (expected_rsp.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		$display("Ran %0d lock requests yielding %0d results under three stall patterns,",
			request_count, result_count);
		$display("including deadlocks, foreign unlocks, a full wait queue and bulk resumes.");
		if (error_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
